[design/dtp_pkg.sv]
// Shared types and codes for the divider and timer peripheral.
// No dependencies; the stream interfaces and the top level use it.
package dtp_pkg;

    // Request kinds.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_DIV  = 2'd0;
    localparam logic [1:0] REG_TIMA = 2'd1;
    localparam logic [1:0] REG_TMA  = 2'd2;
    localparam logic [1:0] REG_TAC  = 2'd3;

    localparam logic [7:0]  CONTROL_FORCED_ONES = 8'hF8;
    localparam logic [15:0] TICK_INCREMENT      = 16'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] reg_index;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } rsp_t;

endpackage

[design/dtp_req_if.sv]
// Request channel of the divider and timer peripheral.
// Depends on dtp_pkg for the payload type.
interface dtp_req_if;
    logic          valid;
    logic          ready;
    dtp_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/dtp_rsp_if.sv]
// Response channel of the divider and timer peripheral.
// Depends on dtp_pkg for the payload type.
interface dtp_rsp_if;
    logic          valid;
    logic          ready;
    dtp_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/div_tima_timer_peripheral_unit.sv]
// Divider and timer peripheral. Every request transaction (tick, register read or
// register write) yields exactly one response transaction. The block takes one
// request per cycle while the response side does not stall, and answers through
// its input register and its response register: the request is held in the input
// register, and from there the timer state and the response register are updated
// together once the response register is free. Backpressure on the response side stalls
// the input register, which in turn drops req.ready; both stages keep moving while rsp.ready is high.
// Depends on dtp_pkg, dtp_req_if and dtp_rsp_if.
module div_tima_timer_peripheral_unit (
    input  logic          clk,
    input  logic          rst_n,
    dtp_req_if.sink       req,
    dtp_rsp_if.source     rsp
);

    localparam logic [1:0] PHASE_RELOAD = 2'd0;
    localparam logic [1:0] PHASE_DELAY  = 2'd1;
    localparam logic [1:0] PHASE_IDLE   = 2'd2;

    // Pipeline registers.
    logic          s1_valid_reg;
    dtp_pkg::req_t s1_req_reg;
    logic          rsp_valid_reg;
    dtp_pkg::rsp_t rsp_data_reg;

    // Timer state.
    logic [15:0] div_reg, div_next;
    logic [7:0]  timer_reg, timer_next;
    logic [7:0]  modulo_reg, modulo_next;
    logic [7:0]  ctl_reg, ctl_next;
    logic [1:0]  phase_reg, phase_next;

    dtp_pkg::rsp_t rsp_next;
    logic          s2_take;
    logic          s2_fire;

    function automatic logic gated_bit(input logic [15:0] dv, input logic [7:0] ctl);
        logic sel;
        case (ctl[1:0])
            2'd0:    sel = dv[9];
            2'd1:    sel = dv[3];
            2'd2:    sel = dv[5];
            default: sel = dv[7];
        endcase
        return sel & ctl[2];
    endfunction

    assign s2_take   = !rsp_valid_reg || rsp.ready;
    assign s2_fire   = s1_valid_reg && s2_take;
    assign req.ready = !s1_valid_reg || s2_take;

    always_comb
    begin
        logic       check;
        logic [1:0] phase_mid;
        logic [7:0] timer_mid;
        logic [7:0] timer_inc;

        check       = 1'b0;
        phase_mid   = phase_reg;
        timer_mid   = timer_reg;
        div_next    = div_reg;
        modulo_next = modulo_reg;
        ctl_next    = ctl_reg;
        rsp_next    = '0;

        case (s1_req_reg.req_type)
            dtp_pkg::REQ_TICK:
            begin
                if (phase_reg == PHASE_DELAY)
                begin
                    timer_mid          = modulo_reg;
                    rsp_next.timer_irq = 1'b1;
                    phase_mid          = PHASE_RELOAD;
                end
                else
                begin
                    phase_mid = PHASE_IDLE;
                end
                div_next = div_reg + dtp_pkg::TICK_INCREMENT;
                check    = 1'b1;
            end
            dtp_pkg::REQ_READ:
            begin
                unique case (s1_req_reg.reg_index)
                    dtp_pkg::REG_DIV:  rsp_next.read_data = div_reg[15:8];
                    dtp_pkg::REG_TIMA: rsp_next.read_data = timer_reg;
                    dtp_pkg::REG_TMA:  rsp_next.read_data = modulo_reg;
                    default:           rsp_next.read_data = ctl_reg;
                endcase
            end
            dtp_pkg::REQ_WRITE:
            begin
                unique case (s1_req_reg.reg_index)
                    dtp_pkg::REG_DIV:
                    begin
                        div_next = '0;
                        check    = 1'b1;
                    end
                    dtp_pkg::REG_TIMA:
                    begin
                        // Ignored on the reload tick; elsewhere it cancels a pending reload.
                        if (phase_reg != PHASE_RELOAD)
                        begin
                            timer_mid = s1_req_reg.write_data;
                            phase_mid = PHASE_IDLE;
                        end
                    end
                    dtp_pkg::REG_TMA:
                    begin
                        modulo_next = s1_req_reg.write_data;
                        if (phase_reg == PHASE_RELOAD)
                        begin
                            timer_mid = s1_req_reg.write_data;
                        end
                    end
                    default:
                    begin
                        ctl_next = s1_req_reg.write_data | dtp_pkg::CONTROL_FORCED_ONES;
                        check    = 1'b1;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        // A falling edge of the gated divider bit counts, except during the delay.
        timer_inc  = timer_mid + 8'd1;
        timer_next = timer_mid;
        phase_next = phase_mid;
        if (check && phase_mid != PHASE_DELAY && gated_bit(div_reg, ctl_reg)
            && !gated_bit(div_next, ctl_next))
        begin
            timer_next = timer_inc;
            if (timer_inc == 8'd0)
            begin
                phase_next = PHASE_DELAY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            div_reg       <= '0;
            timer_reg     <= '0;
            modulo_reg    <= '0;
            ctl_reg       <= '0;
            phase_reg     <= PHASE_RELOAD;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_fire)
            begin
                rsp_valid_reg <= 1'b1;
                div_reg       <= div_next;
                timer_reg     <= timer_next;
                modulo_reg    <= modulo_next;
                ctl_reg       <= ctl_next;
                phase_reg     <= phase_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_req_reg <= req.payload;
        end
        if (s2_fire)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    // The counter sits at zero for the whole delay after a wrap.
    a_delay_counter_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PHASE_DELAY |-> timer_reg == 8'd0)
        else $error("counter not zero during overflow delay");

    // A tick that ends the delay must come out as an interrupt response.
    a_reload_irq: assert property (@(posedge clk) disable iff (!rst_n)
        s2_fire && s1_req_reg.req_type == dtp_pkg::REQ_TICK && phase_reg == PHASE_DELAY
        |=> rsp.valid && rsp.payload.timer_irq)
        else $error("reload tick did not raise the interrupt");

    // With both stages full and the output stalled, no request may be taken.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && rsp.valid && !rsp.ready |-> !req.ready)
        else $error("request accepted while pipeline is full");

    // Once written, the control byte always reads back with its upper bits set.
    a_control_upper: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg != 8'd0 |-> ctl_reg[7:3] == 5'b11111)
        else $error("control upper bits not forced");

endmodule
